### src/gpve_pkg.sv
package gpve_pkg;

   // Fixed field widths of the item and result formats.
   localparam int ELEV_W  = 16;
   localparam int POS_W   = 6;
   localparam int CNT_W   = 12;
   localparam int CFG_W   = 7;
   localparam int IDX_W   = 8;
   localparam int RSP_DATA_W = 56;

   // Default grid dimension limit and configuration reset value.
   localparam int GPVE_MAX_DIM = 64;
   localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

   // Result queue sizing: up to four results are pushed for one item.
   localparam int QDEPTH    = 8;
   localparam int QAW       = 3;
   localparam int PUSH_MAX  = 4;
   localparam logic [CNT_W-1:0] CNT_SAT = 12'hFFF;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_NUM_ROWS = 8'd0;
   localparam logic [IDX_W-1:0] CSR_NUM_COLS = 8'd1;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_MAX    = 2'd1,
      KIND_MIN    = 2'd2,
      KIND_TOTALS = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [POS_W-1:0]          row;
      logic [POS_W-1:0]          col;
      logic signed [ELEV_W-1:0]  value;
      logic                      is_peak;
      logic                      is_valley;
      logic [CNT_W-1:0]          peak_count;
      logic [CNT_W-1:0]          valley_count;
      logic                      last;
   } result_type;

endpackage

### src/gpve_ram.sv
module gpve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port; a read in the write cycle sees old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/gpve_rsp_queue.sv
module gpve_rsp_queue
   import gpve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  push_cnt,
   input  result_type  push_data [PUSH_MAX],
   input  logic        pop,
   output result_type  head,
   output logic [QAW:0] count
);

   result_type        entry_ff [QDEPTH];
   logic [QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]      count_ff, count_in;

   // Store up to four results per cycle at consecutive slots.
   always_ff @(posedge clock) begin
      for (int k = 0; k < PUSH_MAX; k++) begin
         if (3'(k) < push_cnt) begin
            entry_ff[QAW'(wr_ptr_ff + QAW'(k))] <= push_data[k];
         end
      end
   end

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = QAW'(wr_ptr_ff + QAW'(push_cnt));
      rd_ptr_in = pop ? QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = (QAW+1)'(count_ff + (QAW+1)'(push_cnt) - (QAW+1)'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH))
      else $error("result queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue popped while empty");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 3'd0 && !pop) |=> count_ff > $past(count_ff))
      else $error("pushed results not counted");
`endif

endmodule

### src/grid_peak_valley_extremes.sv
// A sample's reports enter the result queue when it retires from stage one; at frame end the
// maximum, minimum and totals follow any point report, one per cycle while rsp_tready is set.
// Throughput: one sample per cycle, set by one line-store read and one write-back per sample;
// the input stalls only while the eight-entry result queue holds more than four results.
// Reset clears the counters, the window, the pipeline and the result queue, and sets both
// dimensions to 64; the line store is not cleared and holds stale rows until overwritten.
module grid_peak_valley_extremes
   import gpve_pkg::*;
#(
   parameter int MAX_DIM = GPVE_MAX_DIM
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input item channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ELEV_W-1:0]      req_tdata,   // [15:0] elevation
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // row, col, value, is_peak, is_valley,
                                               // peak_count, valley_count, 2 zero bits
   output logic [1:0]             rsp_tuser,   // [1:0] kind
   output logic                   rsp_tlast,   // last
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int EW = (DW > CFG_W) ? DW : CFG_W;
   localparam int NW = DW + 1;
   localparam int LW = 2 * ELEV_W;

   logic [CFG_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [EW-1:0]    rows_ext, cols_ext;
   logic [NW-1:0]    rows_eff, cols_eff;

   logic             accept;
   logic [CW-1:0]    row_ff, row_in, col_ff, col_in;

   logic                     s1_valid_ff;
   logic signed [ELEV_W-1:0] s1_x_ff;
   logic [CW-1:0]            s1_row_ff, s1_col_ff;
   logic                     fwd_ff, fwd_in;
   logic [LW-1:0]            fwd_data_ff;

   logic [LW-1:0]            ram_rdata, line_word, wb_data;
   logic signed [ELEV_W-1:0] top, mid, ctr;
   logic signed [ELEV_W-1:0] win_ff [6];

   logic             retire, interior, pk, vl, point, frame_end, first;
   logic [NW-1:0]    r_ext, c_ext;

   logic signed [ELEV_W-1:0] max_ff, max_in, min_ff, min_in;
   logic [POS_W-1:0]         max_row_ff, max_row_in, max_col_ff, max_col_in;
   logic [POS_W-1:0]         min_row_ff, min_row_in, min_col_ff, min_col_in;
   logic [CNT_W-1:0]         peak_ff, peak_in, valley_ff, valley_in;

   result_type       point_res, max_res, min_res, tot_res, head;
   result_type       push_data [PUSH_MAX];
   logic [2:0]       push_cnt;
   logic [QAW:0]     q_count;

   // Configuration registers; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= DIM_RESET;
         cols_cfg_ff <= DIM_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_NUM_ROWS) begin
            rows_cfg_ff <= csr_wdata;
         end
         if (csr_index == CSR_NUM_COLS) begin
            cols_cfg_ff <= csr_wdata;
         end
      end
   end

   // Effective dimensions: zero acts as one, large values clamp to the limit.
   always_comb begin
      rows_ext = EW'(rows_cfg_ff);
      cols_ext = EW'(cols_cfg_ff);
      if (rows_ext == '0) begin
         rows_eff = NW'(1);
      end else if (rows_ext > EW'(MAX_DIM)) begin
         rows_eff = NW'(MAX_DIM);
      end else begin
         rows_eff = NW'(rows_ext);
      end
      if (cols_ext == '0) begin
         cols_eff = NW'(1);
      end else if (cols_ext > EW'(MAX_DIM)) begin
         cols_eff = NW'(MAX_DIM);
      end else begin
         cols_eff = NW'(cols_ext);
      end
   end

   // Stage one retires when the queue has room for a full burst of results.
   assign retire     = s1_valid_ff && (q_count <= (QAW+1)'(QDEPTH - PUSH_MAX));
   assign req_tready = !s1_valid_ff || retire;
   assign accept     = req_tvalid && req_tready;

   // Raster position of the next sample; it addresses the line store.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (NW'(col_ff) + NW'(1) >= cols_eff) begin
         col_in = '0;
         if (NW'(row_ff) + NW'(1) >= rows_eff) begin
            row_in = '0;
         end else begin
            row_in = CW'(row_ff + 1'b1);
         end
      end else begin
         col_in = CW'(col_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line store: upper row in the high half, middle row in the low half.
   gpve_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_DIM)
   ) u_line_ram (
      .clock (clock),
      .we    (retire),
      .waddr (s1_col_ff),
      .wdata (wb_data),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // Forward the write-back when it hits the entry being read in the same cycle.
   assign fwd_in = retire && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= fwd_in;
         end else if (retire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= signed'(req_tdata);
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         fwd_data_ff <= wb_data;
      end
   end

   assign line_word = fwd_ff ? fwd_data_ff : ram_rdata;
   assign top       = signed'(line_word[LW-1:ELEV_W]);
   assign mid       = signed'(line_word[ELEV_W-1:0]);
   assign wb_data   = {mid, s1_x_ff};

   // Window columns: entries 0..2 two columns back, 3..5 one column back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else if (retire) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_x_ff;
      end
   end

   // Peak and valley tests on the cell one row up and one column left.
   always_comb begin
      r_ext    = NW'(s1_row_ff);
      c_ext    = NW'(s1_col_ff);
      ctr      = win_ff[4];
      interior = (r_ext >= NW'(2)) && (c_ext >= NW'(2)) &&
                 (r_ext + NW'(1) <= rows_eff) && (c_ext + NW'(1) <= cols_eff);
      pk = interior && (ctr > win_ff[0]) && (ctr > win_ff[1]) && (ctr > win_ff[2]) &&
           (ctr > win_ff[3]) && (ctr > win_ff[5]) && (ctr > top) && (ctr > mid) &&
           (ctr > s1_x_ff);
      vl = interior && (ctr < win_ff[3]) && (ctr < win_ff[5]) && (ctr < win_ff[1]) &&
           (ctr < mid);
      point     = pk || vl;
      frame_end = (c_ext + NW'(1) >= cols_eff) && (r_ext + NW'(1) >= rows_eff);
      first     = (s1_row_ff == '0) && (s1_col_ff == '0);
   end

   // Running extremes (first in raster order wins) and saturating totals.
   always_comb begin
      max_in     = max_ff;
      max_row_in = max_row_ff;
      max_col_in = max_col_ff;
      min_in     = min_ff;
      min_row_in = min_row_ff;
      min_col_in = min_col_ff;
      if (first) begin
         max_in     = s1_x_ff;
         min_in     = s1_x_ff;
         max_row_in = '0;
         max_col_in = '0;
         min_row_in = '0;
         min_col_in = '0;
      end else begin
         if (s1_x_ff > max_ff) begin
            max_in     = s1_x_ff;
            max_row_in = POS_W'(s1_row_ff);
            max_col_in = POS_W'(s1_col_ff);
         end
         if (s1_x_ff < min_ff) begin
            min_in     = s1_x_ff;
            min_row_in = POS_W'(s1_row_ff);
            min_col_in = POS_W'(s1_col_ff);
         end
      end
      peak_in   = (pk && peak_ff != CNT_SAT) ? CNT_W'(peak_ff + 1'b1) : peak_ff;
      valley_in = (vl && valley_ff != CNT_SAT) ? CNT_W'(valley_ff + 1'b1) : valley_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_row_ff <= '0;
         max_col_ff <= '0;
         min_row_ff <= '0;
         min_col_ff <= '0;
         peak_ff    <= '0;
         valley_ff  <= '0;
      end else if (retire) begin
         max_row_ff <= max_row_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         min_col_ff <= min_col_in;
         peak_ff    <= frame_end ? '0 : peak_in;
         valley_ff  <= frame_end ? '0 : valley_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   // Result items of the retiring sample, in report order.
   always_comb begin
      point_res           = '0;
      point_res.kind      = KIND_POINT;
      point_res.row       = POS_W'(s1_row_ff - 1'b1);
      point_res.col       = POS_W'(s1_col_ff - 1'b1);
      point_res.value     = ctr;
      point_res.is_peak   = pk;
      point_res.is_valley = vl;

      max_res       = '0;
      max_res.kind  = KIND_MAX;
      max_res.row   = max_row_in;
      max_res.col   = max_col_in;
      max_res.value = max_in;

      min_res       = '0;
      min_res.kind  = KIND_MIN;
      min_res.row   = min_row_in;
      min_res.col   = min_col_in;
      min_res.value = min_in;

      tot_res              = '0;
      tot_res.kind         = KIND_TOTALS;
      tot_res.peak_count   = peak_in;
      tot_res.valley_count = valley_in;
      tot_res.last         = 1'b1;

      push_data[0] = point ? point_res : max_res;
      push_data[1] = point ? max_res : min_res;
      push_data[2] = point ? min_res : tot_res;
      push_data[3] = tot_res;

      if (retire) begin
         push_cnt = 3'(point) + (frame_end ? 3'd3 : 3'd0);
      end else begin
         push_cnt = 3'd0;
      end
   end

   gpve_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (push_data),
      .pop       (rsp_tvalid && rsp_tready),
      .head      (head),
      .count     (q_count)
   );

   // Result channel packing.
   assign rsp_tvalid = (q_count != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {2'b00, head.valley_count, head.peak_count, head.is_valley,
                        head.is_peak, head.value, head.col, head.row};

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> retire)
      else $error("sample entered stage one before the previous one retired");
   a_frame_end_reported: assert property (@(posedge clock) disable iff (reset)
      (retire && frame_end) |=> rsp_tvalid)
      else $error("frame end produced no report");
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      retire |-> q_count <= (QAW+1)'(QDEPTH - PUSH_MAX))
      else $error("retire without room for a full burst");
   a_fwd_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (accept && !retire) |=> !fwd_ff)
      else $error("forwarding set without a concurrent write-back");
`endif

endmodule
